// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl block scanner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CKSB_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");
`define CKSB_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define CKSB_ASSERT_IMPL(lbl, clk, rst, a, b)
`define CKSB_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== rtl/cksb_pkg.sv =====
// types and constants of the colour-keyed scaled clipped blit
package cksb_pkg;

   localparam int CRD_W  = 11;
   localparam int PROD_W = 21;
   localparam int ADDR_W = 19;
   localparam int IN_BITS  = 47;
   localparam int IN_BYTES = 48;
   localparam int OUT_BITS  = 27;
   localparam int OUT_BYTES = 32;

   localparam logic [2:0] REG_DEST_X = 3'd0;
   localparam logic [2:0] REG_DEST_Y = 3'd1;
   localparam logic [2:0] REG_SCALE  = 3'd2;
   localparam logic [2:0] REG_CLIP_X = 3'd3;
   localparam logic [2:0] REG_CLIP_Y = 3'd4;
   localparam logic [2:0] REG_CLIP_W = 3'd5;
   localparam logic [2:0] REG_CLIP_H = 3'd6;
   localparam logic [2:0] REG_KEYS   = 3'd7;

   localparam logic [2:0]  SCALE_RST  = 3'd2;
   localparam logic [10:0] CLIP_W_RST = 11'd640;
   localparam logic [10:0] CLIP_H_RST = 11'd480;

   typedef struct packed {
      logic signed [10:0] dest_x;
      logic signed [10:0] dest_y;
      logic [2:0]         scale;
      logic signed [10:0] clip_x;
      logic signed [10:0] clip_y;
      logic [10:0]        clip_w;
      logic [10:0]        clip_h;
      logic [31:0]        key_colours;
   } cfg_type;

   // msb first: colour sits in the top bits of tdata
   typedef struct packed {
      logic [7:0]         colour;
      logic [7:0]         win_y;
      logic [8:0]         win_x;
      logic signed [10:0] src_row;
      logic signed [10:0] src_col;
   } req_item_type;

   typedef struct packed {
      logic [7:0]        pixel_value;
      logic [ADDR_W-1:0] write_addr;
   } rsp_item_type;

   typedef struct packed {
      logic [CRD_W-1:0] xs;
      logic [CRD_W-1:0] xe;
      logic [CRD_W-1:0] ys;
      logic [CRD_W-1:0] ye;
      logic [7:0]       colour;
   } span_type;

   typedef struct packed {
      logic [CRD_W-1:0] px;
      logic [CRD_W-1:0] py;
      logic [7:0]       colour;
      logic             last;
   } wr_type;

endpackage

// ===== rtl/color_keyed_scaled_clipped_blit_core.sv =====
// top level of the colour-keyed scaled clipped blit: registers and pipeline
// Each accepted source pixel is checked against the source frame and four key
// colours, then expanded into a scale x scale block clipped to the clip
// rectangle and the destination frame. A three-stage front pipeline finds the
// visible part of the block; a scanner then issues one write per cycle from it
// while the output is not stalled, so a pixel occupies the scanner until its
// last visible write is taken (up to scale squared writes, four at scale 2) and
// a pixel that is dropped or fully clipped never reaches the scanner. The
// scanner is the throughput limit: the output sustains one write per cycle when
// not stalled. The first write of a pixel passes through the three front stages,
// the scanner register, then a two-stage address pipeline whose second stage is
// the output register; the rest of its block follows one write a cycle while
// the output is not stalled. Registers are written through the csr port; the
// user must write them only while the block is idle; it does not enforce this.
module color_keyed_scaled_clipped_blit_core #(
   parameter int DST_W     = 640,
   parameter int DST_H     = 480,
   parameter int SRC_W     = 320,
   parameter int SRC_H     = 200,
   parameter int MAX_SCALE = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [31:0]                        csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // src_col, src_row, win_x, win_y, colour, zero pad
   input  logic [cksb_pkg::IN_BYTES-1:0]      req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // write_addr, pixel_value, zero pad
   output logic [cksb_pkg::OUT_BYTES-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import cksb_pkg::*;

   cfg_type      cfg_ff;
   req_item_type req_item;
   rsp_item_type rsp_item;
   span_type     span;
   wr_type       wr;
   logic         span_valid, span_ready;
   logic         wr_valid, wr_ready;

   assign req_item  = req_item_type'(req_tdata[IN_BITS-1:0]);
   assign rsp_tdata = {(OUT_BYTES - OUT_BITS)'(0), rsp_item};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x      <= '0;
         cfg_ff.dest_y      <= '0;
         cfg_ff.scale       <= SCALE_RST;
         cfg_ff.clip_x      <= '0;
         cfg_ff.clip_y      <= '0;
         cfg_ff.clip_w      <= CLIP_W_RST;
         cfg_ff.clip_h      <= CLIP_H_RST;
         cfg_ff.key_colours <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEST_X: cfg_ff.dest_x      <= $signed(csr_wdata[10:0]);
            REG_DEST_Y: cfg_ff.dest_y      <= $signed(csr_wdata[10:0]);
            REG_SCALE:  cfg_ff.scale       <= csr_wdata[2:0];
            REG_CLIP_X: cfg_ff.clip_x      <= $signed(csr_wdata[10:0]);
            REG_CLIP_Y: cfg_ff.clip_y      <= $signed(csr_wdata[10:0]);
            REG_CLIP_W: cfg_ff.clip_w      <= csr_wdata[10:0];
            REG_CLIP_H: cfg_ff.clip_h      <= csr_wdata[10:0];
            REG_KEYS:   cfg_ff.key_colours <= csr_wdata;
            default:    cfg_ff             <= cfg_ff;
         endcase
      end
   end

   cksb_front #(
      .DST_W     (DST_W),
      .DST_H     (DST_H),
      .SRC_W     (SRC_W),
      .SRC_H     (SRC_H),
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (span_valid),
      .out_ready (span_ready),
      .out_span  (span)
   );

   cksb_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (span_valid),
      .in_ready  (span_ready),
      .in_span   (span),
      .out_valid (wr_valid),
      .out_ready (wr_ready),
      .out_wr    (wr)
   );

   cksb_addr #(
      .DST_W (DST_W)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wr_valid),
      .in_ready  (wr_ready),
      .in_wr     (wr),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== rtl/cksb_front.sv =====
// front pipeline: source and key checks, block origin, clip intersection
module cksb_front #(
   parameter int DST_W     = 640,
   parameter int DST_H     = 480,
   parameter int SRC_W     = 320,
   parameter int SRC_H     = 200,
   parameter int MAX_SCALE = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cksb_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cksb_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cksb_pkg::span_type     out_span
);
   import cksb_pkg::*;

   localparam int SW = $clog2(MAX_SCALE + 1);
   localparam int PW = 9 + SW;
   localparam int CW = ((PW > 11) ? PW : 11) + 3;
   localparam logic signed [11:0] SRC_W_S = 12'(SRC_W);
   localparam logic signed [11:0] SRC_H_S = 12'(SRC_H);
   localparam logic signed [CW-1:0] DST_W_S = CW'(DST_W);
   localparam logic signed [CW-1:0] DST_H_S = CW'(DST_H);

   logic [SW-1:0]          s_clamp;
   logic                   is_key;
   logic                   keep;
   logic                   rdy1, rdy2, rdy3;

   logic                   v1_ff, v2_ff, v3_ff;
   logic [PW-1:0]          wxs_ff, wys_ff;
   logic [SW-1:0]          s1_ff;
   logic [7:0]             c1_ff, c2_ff;
   logic signed [CW-1:0]   ox_ff, oy_ff, oxe_ff, oye_ff;
   logic signed [CW-1:0]   ox_in, oy_in, oxe_in, oye_in;
   logic signed [CW-1:0]   lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [CW-1:0]   lo_x_in, lo_y_in, hi_x_in, hi_y_in;
   logic signed [CW-1:0]   rsum_x, rsum_y;
   logic signed [CW-1:0]   xs, xe, ys, ye;
   logic                   nonempty;
   span_type               span_ff;

   // stage 1: drop tests and offset times scale
   always_comb begin
      if (cfg.scale == 3'd0) begin
         s_clamp = '0;
      end else if (int'(cfg.scale) > MAX_SCALE) begin
         s_clamp = SW'(MAX_SCALE);
      end else begin
         s_clamp = SW'(cfg.scale);
      end
      is_key = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (cfg.key_colours[8*i +: 8] == in_item.colour) begin
            is_key = 1'b1;
         end
      end
      keep = (s_clamp != '0) && !in_item.src_col[10] && !in_item.src_row[10]
             && (in_item.src_col < SRC_W_S) && (in_item.src_row < SRC_H_S) && !is_key;
   end

   // clip bounds folded with the frame, from configuration only
   always_comb begin
      rsum_x = CW'(cfg.clip_x) + CW'($signed({1'b0, cfg.clip_w}));
      rsum_y = CW'(cfg.clip_y) + CW'($signed({1'b0, cfg.clip_h}));
      lo_x_in = cfg.clip_x[10] ? '0 : CW'(cfg.clip_x);
      lo_y_in = cfg.clip_y[10] ? '0 : CW'(cfg.clip_y);
      hi_x_in = (rsum_x < DST_W_S) ? rsum_x : DST_W_S;
      hi_y_in = (rsum_y < DST_H_S) ? rsum_y : DST_H_S;
   end

   always_ff @(posedge clock) begin
      lo_x_ff <= lo_x_in;
      lo_y_ff <= lo_y_in;
      hi_x_ff <= hi_x_in;
      hi_y_ff <= hi_y_in;
   end

   // stage 2: block corners
   always_comb begin
      ox_in  = CW'(cfg.dest_x) + CW'($signed({1'b0, wxs_ff}));
      oy_in  = CW'(cfg.dest_y) + CW'($signed({1'b0, wys_ff}));
      oxe_in = ox_in + CW'($signed({1'b0, s1_ff}));
      oye_in = oy_in + CW'($signed({1'b0, s1_ff}));
   end

   // stage 3: visible part of the block
   always_comb begin
      xs = (ox_ff > lo_x_ff) ? ox_ff : lo_x_ff;
      ys = (oy_ff > lo_y_ff) ? oy_ff : lo_y_ff;
      xe = (oxe_ff < hi_x_ff) ? oxe_ff : hi_x_ff;
      ye = (oye_ff < hi_y_ff) ? oye_ff : hi_y_ff;
      nonempty = (xs < xe) && (ys < ye);
   end

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v3_ff;
   assign out_span  = span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid && keep;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff && nonempty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         wxs_ff <= PW'(in_item.win_x) * PW'(s_clamp);
         wys_ff <= PW'(in_item.win_y) * PW'(s_clamp);
         s1_ff  <= s_clamp;
         c1_ff  <= in_item.colour;
      end
      if (rdy2) begin
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         oxe_ff <= oxe_in;
         oye_ff <= oye_in;
         c2_ff  <= c1_ff;
      end
      if (rdy3) begin
         span_ff.xs     <= xs[CRD_W-1:0];
         span_ff.xe     <= xe[CRD_W-1:0];
         span_ff.ys     <= ys[CRD_W-1:0];
         span_ff.ye     <= ye[CRD_W-1:0];
         span_ff.colour <= c2_ff;
      end
   end

endmodule

// ===== rtl/cksb_scan.sv =====
// block scanner: walks the visible rectangle by rows, a write per ready cycle
`include "assert_macros.svh"
module cksb_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cksb_pkg::span_type  in_span,
   output logic               out_valid,
   input  logic               out_ready,
   output cksb_pkg::wr_type    out_wr
);
   import cksb_pkg::*;

   logic             busy_ff;
   logic [CRD_W-1:0] px_ff, py_ff, xs_ff, xe_ff, ye_ff;
   logic [7:0]       colour_ff;
   logic [CRD_W-1:0] px_inc, py_inc;
   logic             row_end, last, take, load;

   always_comb begin
      px_inc  = px_ff + CRD_W'(1);
      py_inc  = py_ff + CRD_W'(1);
      row_end = (px_inc == xe_ff);
      last    = row_end && (py_inc == ye_ff);
      take    = busy_ff && out_ready;
      load    = in_valid && in_ready;
   end

   assign in_ready  = !busy_ff || (out_ready && last);
   assign out_valid = busy_ff;
   assign out_wr    = '{px: px_ff, py: py_ff, colour: colour_ff, last: last};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (take && last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff     <= in_span.xs;
         py_ff     <= in_span.ys;
         xs_ff     <= in_span.xs;
         xe_ff     <= in_span.xe;
         ye_ff     <= in_span.ye;
         colour_ff <= in_span.colour;
      end else if (take) begin
         if (row_end) begin
            px_ff <= xs_ff;
            py_ff <= py_inc;
         end else begin
            px_ff <= px_inc;
         end
      end
   end

   `CKSB_ASSERT_IMPL(a_col_in_span, clock, reset, busy_ff, px_ff < xe_ff && px_ff >= xs_ff)
   `CKSB_ASSERT_IMPL(a_row_in_span, clock, reset, busy_ff, py_ff < ye_ff)
   `CKSB_ASSERT_NEXT(a_mid_block_holds, clock, reset, take && !last,
                     busy_ff && $stable(colour_ff) && $stable(xe_ff))

endmodule

// ===== rtl/cksb_addr.sv =====
// address pipeline: row times frame width, add column, output register
module cksb_addr #(
   parameter int DST_W = 640
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cksb_pkg::wr_type       in_wr,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cksb_pkg::rsp_item_type out_item,
   output logic                  out_last
);
   import cksb_pkg::*;

   logic              v5_ff, v6_ff;
   logic              rdy5, rdy6;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] sum;
   logic [CRD_W-1:0]  px5_ff;
   logic [7:0]        c5_ff;
   logic              last5_ff, last6_ff;
   rsp_item_type      item6_ff;

   assign rdy6 = !v6_ff || out_ready;
   assign rdy5 = !v5_ff || rdy6;
   assign in_ready  = rdy5;
   assign out_valid = v6_ff;
   assign out_item  = item6_ff;
   assign out_last  = last6_ff;
   assign sum = prod_ff + PROD_W'(px5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy5) begin
            v5_ff <= in_valid;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         prod_ff  <= PROD_W'(in_wr.py) * PROD_W'(DST_W);
         px5_ff   <= in_wr.px;
         c5_ff    <= in_wr.colour;
         last5_ff <= in_wr.last;
      end
      if (rdy6) begin
         item6_ff.write_addr  <= sum[ADDR_W-1:0];
         item6_ff.pixel_value <= c5_ff;
         last6_ff             <= last5_ff;
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the colour-keyed scaled clipped blit core
module testbench;
   import cksb_pkg::*;

   localparam int DST_W        = 640;
   localparam int DST_H        = 480;
   localparam int SRC_W        = 320;
   localparam int SRC_H        = 200;
   localparam int MAX_SCALE    = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 1000;
   localparam int PHASES       = 10;
   localparam int MODEL_ONLY   = -1;

   typedef struct packed {
      rsp_item_type data;
      logic         last;
   } pixel_write_type;

   typedef struct {
      int col;
      int row;
      int wx;
      int wy;
      int colour;
      int n_writes;
      int base;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_DEST_X;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [IN_BYTES-1:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [OUT_BYTES-1:0] rsp_tdata;
   logic        rsp_tlast;

   cfg_type         blit_cfg;
   pixel_write_type pending_writes[$];
   int              err_count = 0;
   int              stall_cycles = 0;
   int              src_idle_pct = 23;
   int              snk_idle_pct = 49;

   // reset register set for every row: scale 2, full clip, key 0
   dir_row_type dir_rows [16] = '{
      '{    0,     0,   0,   0, 'h01, 4,      0},
      '{  319,   199, 319, 199, 'hFF, 4, 255358},
      '{  319,     0, 319,   0, 'h80, 4,    638},
      '{    0,   199,   0, 199, 'h7F, 4, 254720},
      '{   10,    10,  10,  10, 'h00, 0,      0},
      '{   -1,    10,  10,  10, 'h11, 0,      0},
      '{  320,    10,  10,  10, 'h11, 0,      0},
      '{   10,    -1,  10,  10, 'h11, 0,      0},
      '{   10,   200,  10,  10, 'h11, 0,      0},
      '{-1024, -1024,   0,   0, 'h22, 0,      0},
      '{ 1023,  1023,   0,   0, 'h22, 0,      0},
      '{   10,    10, 511,  10, 'h33, 0,      0},
      '{   10,    10,  10, 255, 'h44, 0,      0},
      '{   10,    10, 319, 239, 'h55, MODEL_ONLY, 0},
      '{  123,    45, 200, 100, 'hA5, MODEL_ONLY, 0},
      '{    1,     1, 256, 128, 'h5A, MODEL_ONLY, 0}
   };

   color_keyed_scaled_clipped_blit_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int eff_scale();
      return (blit_cfg.scale > MAX_SCALE) ? MAX_SCALE : int'(blit_cfg.scale);
   endfunction

   // queue the writes that one source pixel should produce
   function automatic void predict_block(input req_item_type it);
      int s, scol, srow, ox, oy, cx, cy, clip_r, clip_b, px, py, first;
      bit keyed;
      pixel_write_type w;
      s = eff_scale();
      if (s == 0)
         return;
      scol = $signed(it.src_col);
      srow = $signed(it.src_row);
      if (scol < 0 || scol >= SRC_W || srow < 0 || srow >= SRC_H)
         return;
      keyed = 1'b0;
      for (int i = 0; i < 4; i++)
         if (blit_cfg.key_colours[8*i +: 8] == it.colour)
            keyed = 1'b1;
      if (keyed)
         return;
      ox = $signed(blit_cfg.dest_x) + int'(it.win_x) * s;
      oy = $signed(blit_cfg.dest_y) + int'(it.win_y) * s;
      cx = $signed(blit_cfg.clip_x);
      cy = $signed(blit_cfg.clip_y);
      clip_r = cx + int'(blit_cfg.clip_w);
      clip_b = cy + int'(blit_cfg.clip_h);
      first = pending_writes.size();
      for (int yy = 0; yy < s; yy++) begin
         py = oy + yy;
         if (py < cy || py >= clip_b || py < 0 || py >= DST_H)
            continue;
         for (int xx = 0; xx < s; xx++) begin
            px = ox + xx;
            if (px < cx || px >= clip_r || px < 0 || px >= DST_W)
               continue;
            w.data.write_addr  = ADDR_W'(py * DST_W + px);
            w.data.pixel_value = it.colour;
            w.last             = 1'b0;
            pending_writes.push_back(w);
         end
      end
      if (pending_writes.size() > first)
         pending_writes[$].last = 1'b1;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.scale  = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
      c.dest_x = ($urandom_range(9) == 0) ? (($urandom_range(1)) ? 11'sd1023 : -11'sd1024)
                                          : 11'(pick(-64, 400));
      c.dest_y = ($urandom_range(9) == 0) ? (($urandom_range(1)) ? 11'sd1023 : -11'sd1024)
                                          : 11'(pick(-64, 300));
      if ($urandom_range(9) == 0) begin
         c.clip_x = -11'sd1024;
         c.clip_y = -11'sd1024;
         c.clip_w = 11'd2047;
         c.clip_h = 11'd2047;
      end else begin
         c.clip_x = 11'(pick(-32, 400));
         c.clip_y = 11'(pick(-32, 300));
         c.clip_w = ($urandom_range(9) == 0) ? 11'd0 : 11'(pick(1, 700));
         c.clip_h = ($urandom_range(9) == 0) ? 11'd0 : 11'(pick(1, 500));
      end
      c.key_colours = $urandom;
      return c;
   endfunction

   function automatic cfg_type extreme_config(input int which);
      cfg_type c;
      c = random_config();
      unique case (which)
         0: begin
            c.scale = 3'd1; c.dest_x = '0; c.dest_y = '0;
            c.clip_x = '0; c.clip_y = '0; c.clip_w = 11'd640; c.clip_h = 11'd480;
            c.key_colours = 32'h0403_0201;
         end
         1: begin
            c.scale = 3'd4; c.dest_x = -11'sd3; c.dest_y = -11'sd5;
            c.clip_x = -11'sd1024; c.clip_y = -11'sd1024;
            c.clip_w = 11'd2047; c.clip_h = 11'd2047;
            c.key_colours = 32'hFFFF_FFFF;
         end
         2: begin
            c.scale = 3'd0; c.dest_x = 11'sd1023; c.dest_y = 11'sd1023;
            c.clip_x = 11'sd1023; c.clip_y = 11'sd1023; c.clip_w = '0; c.clip_h = '0;
            c.key_colours = 32'h8080_8080;
         end
         default: begin
            c.scale = 3'd7; c.dest_x = -11'sd1024; c.dest_y = '0;
            c.clip_x = 11'sd100; c.clip_y = 11'sd50; c.clip_w = 11'd200; c.clip_h = 11'd100;
            c.key_colours = 32'h00FF_7F01;
         end
      endcase
      return c;
   endfunction

   function automatic req_item_type random_pixel();
      req_item_type it;
      int s;
      s = (eff_scale() == 0) ? 1 : eff_scale();
      it.src_col = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(SRC_W - 1));
      it.src_row = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(SRC_H - 1));
      it.win_x   = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(DST_W / s + 8));
      it.win_y   = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(DST_H / s + 8));
      it.colour  = ($urandom_range(3) == 0) ? blit_cfg.key_colours[8*$urandom_range(3) +: 8]
                                            : 8'($urandom);
      return it;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      unique case (idx)
         REG_DEST_X: blit_cfg.dest_x      = value[10:0];
         REG_DEST_Y: blit_cfg.dest_y      = value[10:0];
         REG_SCALE:  blit_cfg.scale       = value[2:0];
         REG_CLIP_X: blit_cfg.clip_x      = value[10:0];
         REG_CLIP_Y: blit_cfg.clip_y      = value[10:0];
         REG_CLIP_W: blit_cfg.clip_w      = value[10:0];
         REG_CLIP_H: blit_cfg.clip_h      = value[10:0];
         REG_KEYS:   blit_cfg.key_colours = value;
         default: ;
      endcase
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(REG_DEST_X, 32'(c.dest_x));
      write_reg(REG_DEST_Y, 32'(c.dest_y));
      write_reg(REG_SCALE,  32'(c.scale));
      write_reg(REG_CLIP_X, 32'(c.clip_x));
      write_reg(REG_CLIP_Y, 32'(c.clip_y));
      write_reg(REG_CLIP_W, 32'(c.clip_w));
      write_reg(REG_CLIP_H, 32'(c.clip_h));
      write_reg(REG_KEYS,   c.key_colours);
      csr_we <= 1'b0;
   endtask

   // wait for all writes, then for any dropped pixels still in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(input req_item_type it);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= IN_BYTES'(it);
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   always @(posedge clock) begin : write_check
      pixel_write_type want;
      rsp_item_type    got;
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_item_type)-1:0];
         if (pending_writes.size() == 0) begin
            $error("unexpected write: write_addr %0d pixel_value %0d", got.write_addr,
                   got.pixel_value);
            err_count++;
         end else begin
            want = pending_writes.pop_front();
            if (got.write_addr !== want.data.write_addr) begin
               $error("write_addr: expected %0d, got %0d", want.data.write_addr,
                      got.write_addr);
               err_count++;
            end
            if (got.pixel_value !== want.data.pixel_value) begin
               $error("pixel_value: expected %0d, got %0d", want.data.pixel_value,
                      got.pixel_value);
               err_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : stimulus
      req_item_type    it;
      pixel_write_type w;
      int              n_items;
      blit_cfg.dest_x      = '0;
      blit_cfg.dest_y      = '0;
      blit_cfg.scale       = SCALE_RST;
      blit_cfg.clip_x      = '0;
      blit_cfg.clip_y      = '0;
      blit_cfg.clip_w      = CLIP_W_RST;
      blit_cfg.clip_h      = CLIP_H_RST;
      blit_cfg.key_colours = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pixels against the reset register set
      foreach (dir_rows[i]) begin
         it.src_col = 11'(dir_rows[i].col);
         it.src_row = 11'(dir_rows[i].row);
         it.win_x   = 9'(dir_rows[i].wx);
         it.win_y   = 8'(dir_rows[i].wy);
         it.colour  = 8'(dir_rows[i].colour);
         if (dir_rows[i].n_writes == MODEL_ONLY)
            predict_block(it);
         else if (dir_rows[i].n_writes == 4) begin
            for (int r = 0; r < 2; r++)
               for (int c = 0; c < 2; c++) begin
                  w.data.write_addr  = ADDR_W'(dir_rows[i].base + r * DST_W + c);
                  w.data.pixel_value = it.colour;
                  w.last             = (r == 1 && c == 1);
                  pending_writes.push_back(w);
               end
         end
         send_pixel(it);
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (p < 4) begin
            src_idle_pct = 23;
            snk_idle_pct = 49;
            load_config(extreme_config(p));
         end else begin
            src_idle_pct = (p < 7) ? 49 : 0;
            snk_idle_pct = (p < 7) ? 23 : 0;
            load_config(random_config());
         end
         n_items = (p == 2) ? 10 : 42;
         for (int n = 0; n < n_items; n++) begin
            it = random_pixel();
            predict_block(it);
            send_pixel(it);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
